// ===== rtl/pcio_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcio_pkg;

    localparam int BUFFER_SLOTS_DEF  = 5;
    localparam int TICKS_PER_IRQ_DEF = 4;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_PUSH  = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [15:0] PORT_PIC_CMD      = 16'h0020;
    localparam logic [15:0] PORT_PIC_MASK     = 16'h0021;
    localparam logic [15:0] PORT_TIMER0       = 16'h0040;
    localparam logic [15:0] PORT_TIMER1       = 16'h0041;
    localparam logic [15:0] PORT_TIMER2       = 16'h0042;
    localparam logic [15:0] PORT_TIMER_CTL    = 16'h0043;
    localparam logic [15:0] PORT_KBD_DATA     = 16'h0060;
    localparam logic [15:0] PORT_KBD_CTL      = 16'h0061;
    localparam logic [15:0] PORT_SERIAL_LSR   = 16'h02FD;
    localparam logic [15:0] PORT_VIDEO_STATUS = 16'h03DA;

    localparam logic [7:0] PIC_EOI          = 8'h20;
    localparam logic [7:0] KBD_CTL_VALUE    = 8'hD0;
    localparam logic [7:0] SERIAL_LSR_VALUE = 8'hFF;
    localparam logic [7:0] VIDEO_TOGGLE     = 8'h09;
    localparam logic [7:0] MASK_RESET       = 8'hFC;

    localparam logic [3:0] VEC_NONE  = 4'd0;
    localparam logic [3:0] VEC_TIMER = 4'd8;
    localparam logic [3:0] VEC_KBD   = 4'd9;

    localparam int LINE_TIMER = 0;
    localparam int LINE_KBD   = 1;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] port;
        logic [7:0]  value;
        logic        last_code;
        logic        cpu_int_enable;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       int_valid;
        logic [3:0] int_vector;
        logic       int_deferred;
        logic [2:0] free_slots;
        logic       overflow;
    } t_out_item;

    typedef struct packed {
        logic       timer_raise;
        logic       kbd_raise;
        logic       eoi;
        logic       deliver;
        logic       ie;
        logic       mask_we;
        logic [7:0] mask_data;
    } t_pic_ev;

    typedef struct packed {
        logic [7:0] mask;
        logic       kbd_in_service;
        logic       int_valid;
        logic [3:0] int_vector;
        logic       int_deferred;
    } t_pic_sts;

    typedef struct packed {
        logic       push;
        logic       pop_req;
        logic       rd;
        logic [7:0] data;
    } t_q_ctl;

    typedef struct packed {
        logic       full;
        logic       refill;
        logic [7:0] kbd_data;
        logic [2:0] free_slots;
    } t_q_sts;

    typedef struct packed {
        logic tick;
        logic timer_rd;
        logic video_rd;
        logic toggle_set;
    } t_reg_ctl;

    typedef struct packed {
        logic       timer_raise;
        logic [7:0] timer_data;
        logic [7:0] video_data;
    } t_reg_sts;

endpackage

`default_nettype wire

// ===== rtl/pcio_pic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcio_pic (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  pcio_pkg::t_pic_ev  i_ev,
    output pcio_pkg::t_pic_sts o_sts
);

    logic [1:0] r_req, n_req;
    logic [1:0] r_is, n_is;
    logic [7:0] r_mask, n_mask;
    logic [1:0] w_req1, w_is1, w_rdy;

    always_comb begin
        w_req1 = r_req | {i_ev.kbd_raise, i_ev.timer_raise};
        w_is1  = i_ev.eoi ? 2'b00 : r_is;
        w_rdy  = w_req1 & ~r_mask[1:0];
        n_req  = w_req1;
        n_is   = w_is1;
        n_mask = i_ev.mask_we ? i_ev.mask_data : r_mask;
        o_sts.mask           = r_mask;
        o_sts.kbd_in_service = r_is[pcio_pkg::LINE_KBD];
        o_sts.int_valid      = 1'b0;
        o_sts.int_vector     = pcio_pkg::VEC_NONE;
        o_sts.int_deferred   = 1'b0;
        if (i_ev.deliver && (w_is1 == 2'b00)) begin
            if (w_rdy[pcio_pkg::LINE_TIMER]) begin
                n_is                          = 2'b00;
                n_is[pcio_pkg::LINE_TIMER]    = 1'b1;
                n_req[pcio_pkg::LINE_TIMER]   = 1'b0;
                o_sts.int_valid               = 1'b1;
                o_sts.int_vector              = pcio_pkg::VEC_TIMER;
                o_sts.int_deferred            = ~i_ev.ie;
            end else if (w_rdy[pcio_pkg::LINE_KBD]) begin
                n_is                          = 2'b00;
                n_is[pcio_pkg::LINE_KBD]      = 1'b1;
                n_req[pcio_pkg::LINE_KBD]     = 1'b0;
                o_sts.int_valid               = 1'b1;
                o_sts.int_vector              = pcio_pkg::VEC_KBD;
                o_sts.int_deferred            = ~i_ev.ie;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req  <= 2'b00;
            r_is   <= 2'b00;
            r_mask <= pcio_pkg::MASK_RESET;
        end else begin
            r_req  <= n_req;
            r_is   <= n_is;
            r_mask <= n_mask;
        end
    end

    a_single_in_service: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_is))
        else $error("more than one line in service");

    a_delivery_sets_service: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.int_valid |=> (r_is != 2'b00))
        else $error("delivered interrupt not in service");

    a_delivery_needs_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sts.int_valid && !i_ev.eoi) |-> (r_is == 2'b00))
        else $error("delivery while a line is in service");

endmodule

`default_nettype wire

// ===== rtl/pcio_scanq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcio_scanq #(
    parameter int BUFFER_SLOTS = pcio_pkg::BUFFER_SLOTS_DEF
) (
    input  wire              logic i_clk,
    input  wire              logic i_rst_n,
    input  pcio_pkg::t_q_ctl i_ctl,
    output pcio_pkg::t_q_sts o_sts
);

    localparam int PW = $clog2(BUFFER_SLOTS);
    localparam int FW = (PW > 3) ? PW : 3;
    localparam logic [PW-1:0] LAST_SLOT = PW'(BUFFER_SLOTS - 1);

    logic [7:0]    mem [BUFFER_SLOTS];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] r_count, n_count;
    logic [7:0]    r_head;
    logic [7:0]    r_last, n_last;
    logic          w_full, w_empty, w_push_ok, w_pop;
    logic [FW-1:0] w_free;

    always_comb begin
        w_full    = (r_count == LAST_SLOT);
        w_empty   = (r_count == '0);
        w_push_ok = i_ctl.push && !w_full;
        w_pop     = i_ctl.pop_req && !w_empty;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_count   = r_count;
        if (w_push_ok) begin
            n_wp    = (r_wp == LAST_SLOT) ? '0 : r_wp + 1'b1;
            n_count = r_count + 1'b1;
        end
        if (w_pop) begin
            n_rp    = (r_rp == LAST_SLOT) ? '0 : r_rp + 1'b1;
            n_count = r_count - 1'b1;
        end
        n_last = (i_ctl.rd && !w_empty) ? r_head : r_last;
        w_free = FW'(BUFFER_SLOTS - 1) - FW'(n_count);
        o_sts.full       = w_full;
        o_sts.refill     = w_pop && (r_count != PW'(1));
        o_sts.kbd_data   = w_empty ? r_last : r_head;
        o_sts.free_slots = w_free[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            mem[r_wp] <= i_ctl.data;
        end
    end

    // head register, bypassed when writing the slot about to be read
    always_ff @(posedge i_clk) begin
        if (w_push_ok && (r_wp == n_rp)) begin
            r_head <= i_ctl.data;
        end else begin
            r_head <= mem[n_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
            r_last  <= 8'h00;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
            r_last  <= n_last;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_SLOT)
        else $error("queue count beyond capacity");

    a_count_matches_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == ((r_wp >= r_rp) ? (r_wp - r_rp) : (PW'(BUFFER_SLOTS) + r_wp - r_rp)))
        else $error("queue count disagrees with pointers");

endmodule

`default_nettype wire

// ===== rtl/pcio_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcio_regs #(
    parameter int TICKS_PER_IRQ = pcio_pkg::TICKS_PER_IRQ_DEF
) (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  pcio_pkg::t_reg_ctl i_ctl,
    output pcio_pkg::t_reg_sts o_sts
);

    localparam int DW = $clog2(TICKS_PER_IRQ + 1);
    localparam logic [DW-1:0] DIV_RELOAD = DW'(TICKS_PER_IRQ);

    logic [DW-1:0] r_div, n_div;
    logic [15:0]   r_latch, n_latch;
    logic          r_toggle, n_toggle;
    logic [7:0]    r_video, n_video;

    always_comb begin
        n_div    = r_div;
        n_latch  = r_latch;
        n_toggle = r_toggle;
        n_video  = r_video;
        o_sts.timer_raise = 1'b0;
        o_sts.timer_data  = r_toggle ? r_latch[7:0] : r_latch[15:8];
        o_sts.video_data  = r_video;
        if (i_ctl.tick) begin
            if (r_div <= DW'(1)) begin
                o_sts.timer_raise = 1'b1;
                n_div             = DIV_RELOAD;
            end else begin
                n_div = r_div - 1'b1;
            end
        end
        if (i_ctl.timer_rd) begin
            n_toggle = ~r_toggle;
            if (!r_toggle) begin
                n_latch = r_latch + 16'd1;
            end
        end
        if (i_ctl.toggle_set) begin
            n_toggle = 1'b1;
        end
        if (i_ctl.video_rd) begin
            n_video = r_video ^ pcio_pkg::VIDEO_TOGGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div    <= DIV_RELOAD;
            r_latch  <= 16'h0000;
            r_toggle <= 1'b1;
            r_video  <= 8'h00;
        end else begin
            r_div    <= n_div;
            r_latch  <= n_latch;
            r_toggle <= n_toggle;
            r_video  <= n_video;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pc_io_port_pic_keyboard.sv =====
`timescale 1ns / 1ps
`default_nettype none

// PC I/O block: port reads and writes, keyboard scancode pushes and timer ticks in,
// one result transaction out for every input transaction, in order. A transaction
// is taken into an input register, processed combinationally against the interrupt
// controller, scancode queue and timer/video registers, and lands in a result
// register; one transaction per clock is sustained while results are taken. The
// input side keeps accepting while a result waits, stalling only when both the
// input and result registers are full and the result is not being taken.
module pc_io_port_pic_keyboard #(
    parameter int BUFFER_SLOTS  = pcio_pkg::BUFFER_SLOTS_DEF,
    parameter int TICKS_PER_IRQ = pcio_pkg::TICKS_PER_IRQ_DEF
) (
    input  wire                 logic i_clk,
    input  wire                 logic i_rst_n,
    input  wire                 logic i_in_valid,
    output logic                o_in_ready,
    input  pcio_pkg::t_in_item  i_item,
    output logic                o_out_valid,
    input  wire                 logic i_out_ready,
    output pcio_pkg::t_out_item o_result
);

    logic                r_in_valid;
    pcio_pkg::t_in_item  r_item;
    logic                r_out_valid;
    pcio_pkg::t_out_item r_out, n_out;
    logic                w_fire;

    pcio_pkg::t_pic_ev  w_pic_ev;
    pcio_pkg::t_pic_sts w_pic_sts;
    pcio_pkg::t_q_ctl   w_q_ctl;
    pcio_pkg::t_q_sts   w_q_sts;
    pcio_pkg::t_reg_ctl w_reg_ctl;
    pcio_pkg::t_reg_sts w_reg_sts;

    logic [7:0] w_rd_data;
    logic       w_push, w_eoi, w_tick;

    assign w_fire      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_fire;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        w_reg_ctl = '0;
        w_q_ctl   = '0;
        w_rd_data = 8'h00;
        w_push    = 1'b0;
        w_eoi     = 1'b0;
        w_tick    = 1'b0;
        w_pic_ev  = '0;
        w_q_ctl.data = r_item.value;
        if (w_fire) begin
            unique case (r_item.command)
                pcio_pkg::CMD_READ: begin
                    unique case (r_item.port) inside
                        pcio_pkg::PORT_PIC_MASK: w_rd_data = w_pic_sts.mask;
                        pcio_pkg::PORT_TIMER0, pcio_pkg::PORT_TIMER1,
                        pcio_pkg::PORT_TIMER2: begin
                            w_reg_ctl.timer_rd = 1'b1;
                            w_rd_data          = w_reg_sts.timer_data;
                        end
                        pcio_pkg::PORT_KBD_DATA: begin
                            w_q_ctl.rd = 1'b1;
                            w_rd_data  = w_q_sts.kbd_data;
                        end
                        pcio_pkg::PORT_KBD_CTL:    w_rd_data = pcio_pkg::KBD_CTL_VALUE;
                        pcio_pkg::PORT_SERIAL_LSR: w_rd_data = pcio_pkg::SERIAL_LSR_VALUE;
                        pcio_pkg::PORT_VIDEO_STATUS: begin
                            w_reg_ctl.video_rd = 1'b1;
                            w_rd_data          = w_reg_sts.video_data;
                        end
                        default: w_rd_data = 8'h00;
                    endcase
                end
                pcio_pkg::CMD_WRITE: begin
                    w_eoi = (r_item.port == pcio_pkg::PORT_PIC_CMD)
                         && (r_item.value == pcio_pkg::PIC_EOI);
                    w_pic_ev.mask_we     = (r_item.port == pcio_pkg::PORT_PIC_MASK);
                    w_reg_ctl.toggle_set = (r_item.port == pcio_pkg::PORT_TIMER_CTL);
                end
                pcio_pkg::CMD_PUSH: w_push = 1'b1;
                pcio_pkg::CMD_TICK: w_tick = 1'b1;
                default: w_tick = 1'b0;
            endcase
        end
        w_reg_ctl.tick       = w_tick;
        w_q_ctl.push         = w_push;
        w_q_ctl.pop_req      = w_eoi && w_pic_sts.kbd_in_service;
        w_pic_ev.timer_raise = w_reg_sts.timer_raise;
        w_pic_ev.kbd_raise   = (w_push && r_item.last_code) || w_q_sts.refill;
        w_pic_ev.eoi         = w_eoi;
        w_pic_ev.deliver     = w_eoi || w_tick;
        w_pic_ev.ie          = r_item.cpu_int_enable;
        w_pic_ev.mask_data   = r_item.value;

        n_out.read_data    = w_rd_data;
        n_out.int_valid    = w_pic_sts.int_valid;
        n_out.int_vector   = w_pic_sts.int_vector;
        n_out.int_deferred = w_pic_sts.int_deferred;
        n_out.free_slots   = w_q_sts.free_slots;
        n_out.overflow     = w_push && w_q_sts.full;
    end

    pcio_pic u_pic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ev    (w_pic_ev),
        .o_sts   (w_pic_sts)
    );

    pcio_scanq #(
        .BUFFER_SLOTS (BUFFER_SLOTS)
    ) u_scanq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_q_ctl),
        .o_sts   (w_q_sts)
    );

    pcio_regs #(
        .TICKS_PER_IRQ (TICKS_PER_IRQ)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_reg_ctl),
        .o_sts   (w_reg_sts)
    );

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_item <= i_item;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== dv/pc_io_port_pic_keyboard_checker.sv =====
`timescale 1ns / 1ps

module pc_io_port_pic_keyboard_checker #(
    parameter int BUFFER_SLOTS  = pcio_pkg::BUFFER_SLOTS_DEF,
    parameter int TICKS_PER_IRQ = pcio_pkg::TICKS_PER_IRQ_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  pcio_pkg::t_in_item  i_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  pcio_pkg::t_out_item i_result,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_irq_count,
    output int                  o_ovf_count
);

    logic [1:0]  irq_req;
    logic [1:0]  in_svc;
    logic [7:0]  imr;
    logic [7:0]  codes [BUFFER_SLOTS];
    int          rd_ptr;
    int          wr_ptr;
    logic [7:0]  kbd_last;
    int          tick_cnt;
    logic [15:0] latch;
    logic        toggle;
    logic [7:0]  video;

    pcio_pkg::t_out_item expected_io[$];
    pcio_pkg::t_out_item want;

    function automatic int slot_after(int p);
        return (p + 1 >= BUFFER_SLOTS) ? 0 : p + 1;
    endfunction

    // timer line wins over keyboard; nothing while a line is in service
    function automatic void take_irq(logic ie, inout pcio_pkg::t_out_item r);
        if (in_svc != 2'b00)
            return;
        if (irq_req[pcio_pkg::LINE_TIMER] && !imr[pcio_pkg::LINE_TIMER]) begin
            in_svc = '0;
            in_svc[pcio_pkg::LINE_TIMER] = 1'b1;
            irq_req[pcio_pkg::LINE_TIMER] = 1'b0;
            r.int_vector = pcio_pkg::VEC_TIMER;
        end else if (irq_req[pcio_pkg::LINE_KBD] && !imr[pcio_pkg::LINE_KBD]) begin
            in_svc = '0;
            in_svc[pcio_pkg::LINE_KBD] = 1'b1;
            irq_req[pcio_pkg::LINE_KBD] = 1'b0;
            r.int_vector = pcio_pkg::VEC_KBD;
        end else begin
            return;
        end
        r.int_valid = 1'b1;
        r.int_deferred = ~ie;
    endfunction

    function automatic pcio_pkg::t_out_item predict_io(pcio_pkg::t_in_item it);
        pcio_pkg::t_out_item r;
        int                  held;
        r = '0;
        case (it.command)
            pcio_pkg::CMD_READ: begin
                case (it.port) inside
                    pcio_pkg::PORT_PIC_MASK: r.read_data = imr;
                    pcio_pkg::PORT_TIMER0, pcio_pkg::PORT_TIMER1,
                    pcio_pkg::PORT_TIMER2: begin
                        toggle = ~toggle;
                        if (!toggle) begin
                            r.read_data = latch[7:0];
                        end else begin
                            r.read_data = latch[15:8];
                            latch = latch + 16'd1;
                        end
                    end
                    pcio_pkg::PORT_KBD_DATA: begin
                        if (rd_ptr != wr_ptr)
                            kbd_last = codes[rd_ptr];
                        r.read_data = kbd_last;
                    end
                    pcio_pkg::PORT_KBD_CTL:    r.read_data = pcio_pkg::KBD_CTL_VALUE;
                    pcio_pkg::PORT_SERIAL_LSR: r.read_data = pcio_pkg::SERIAL_LSR_VALUE;
                    pcio_pkg::PORT_VIDEO_STATUS: begin
                        r.read_data = video;
                        video = video ^ pcio_pkg::VIDEO_TOGGLE;
                    end
                    default: ;
                endcase
            end
            pcio_pkg::CMD_WRITE: begin
                if (it.port == pcio_pkg::PORT_PIC_CMD) begin
                    if (it.value == pcio_pkg::PIC_EOI) begin
                        if (in_svc[pcio_pkg::LINE_KBD] && rd_ptr != wr_ptr) begin
                            rd_ptr = slot_after(rd_ptr);
                            if (rd_ptr != wr_ptr)
                                irq_req[pcio_pkg::LINE_KBD] = 1'b1;
                        end
                        in_svc = '0;
                        take_irq(it.cpu_int_enable, r);
                    end
                end else if (it.port == pcio_pkg::PORT_PIC_MASK) begin
                    imr = it.value;
                end else if (it.port == pcio_pkg::PORT_TIMER_CTL) begin
                    toggle = 1'b1;
                end
            end
            pcio_pkg::CMD_PUSH: begin
                if (slot_after(wr_ptr) == rd_ptr) begin
                    r.overflow = 1'b1;
                end else begin
                    codes[wr_ptr] = it.value;
                    wr_ptr = slot_after(wr_ptr);
                end
                if (it.last_code)
                    irq_req[pcio_pkg::LINE_KBD] = 1'b1;
            end
            default: begin
                if (tick_cnt <= 1) begin
                    irq_req[pcio_pkg::LINE_TIMER] = 1'b1;
                    tick_cnt = TICKS_PER_IRQ;
                end else begin
                    tick_cnt = tick_cnt - 1;
                end
                take_irq(it.cpu_int_enable, r);
            end
        endcase
        held = (wr_ptr + BUFFER_SLOTS - rd_ptr) % BUFFER_SLOTS;
        r.free_slots = 3'(BUFFER_SLOTS - 1 - held);
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] exp);
        $display("%0t mismatch on %s: got %0h expected %0h", $time, what, got, exp);
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            irq_req  = '0;
            in_svc   = '0;
            imr      = pcio_pkg::MASK_RESET;
            rd_ptr   = 0;
            wr_ptr   = 0;
            kbd_last = '0;
            tick_cnt = TICKS_PER_IRQ;
            latch    = '0;
            toggle   = 1'b1;
            video    = '0;
            expected_io.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_io.size() == 0) begin
                    report("unexpected result", 32'(i_result), 32'd0);
                end else begin
                    want = expected_io.pop_front();
                    if (i_result.read_data != want.read_data)
                        report("read_data", 32'(i_result.read_data), 32'(want.read_data));
                    if (i_result.int_valid != want.int_valid)
                        report("int_valid", 32'(i_result.int_valid), 32'(want.int_valid));
                    if (i_result.int_vector != want.int_vector)
                        report("int_vector", 32'(i_result.int_vector),
                               32'(want.int_vector));
                    if (i_result.int_deferred != want.int_deferred)
                        report("int_deferred", 32'(i_result.int_deferred),
                               32'(want.int_deferred));
                    if (i_result.free_slots != want.free_slots)
                        report("free_slots", 32'(i_result.free_slots),
                               32'(want.free_slots));
                    if (i_result.overflow != want.overflow)
                        report("overflow", 32'(i_result.overflow), 32'(want.overflow));
                    o_checked = o_checked + 1;
                    if (want.int_valid)
                        o_irq_count = o_irq_count + 1;
                    if (want.overflow)
                        o_ovf_count = o_ovf_count + 1;
                end
            end
            if (i_in_valid && i_in_ready)
                expected_io.push_back(predict_io(i_item));
        end
        o_pending = expected_io.size();
    end

endmodule

// ===== dv/tb_pc_io_port_pic_keyboard.sv =====
`timescale 1ns / 1ps

module tb_pc_io_port_pic_keyboard;

    localparam int RANDOM_ITEMS = 1400;

    localparam logic [15:0] KNOWN_PORTS [10] = '{
        pcio_pkg::PORT_PIC_CMD, pcio_pkg::PORT_PIC_MASK, pcio_pkg::PORT_TIMER0,
        pcio_pkg::PORT_TIMER1, pcio_pkg::PORT_TIMER2, pcio_pkg::PORT_TIMER_CTL,
        pcio_pkg::PORT_KBD_DATA, pcio_pkg::PORT_KBD_CTL, pcio_pkg::PORT_SERIAL_LSR,
        pcio_pkg::PORT_VIDEO_STATUS
    };

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                i_out_ready = 1'b0;
    pcio_pkg::t_in_item  i_item      = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    pcio_pkg::t_out_item o_result;

    int fail_count;
    int pending;
    int checked;
    int irq_count;
    int ovf_count;
    int in_calm  = 0;
    int out_calm = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    pc_io_port_pic_keyboard dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item      (i_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    pc_io_port_pic_keyboard_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_item       (i_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_irq_count  (irq_count),
        .o_ovf_count  (ovf_count)
    );

    // random waits with occasional back-to-back stretches
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 7) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 15);
    endfunction

    function automatic pcio_pkg::t_in_item make_item(logic [1:0] cmd, logic [15:0] port,
                                                     logic [7:0] value, logic last,
                                                     logic ie);
        pcio_pkg::t_in_item it;
        it.command        = cmd;
        it.port           = port;
        it.value          = value;
        it.last_code      = last;
        it.cpu_int_enable = ie;
        return it;
    endfunction

    function automatic pcio_pkg::t_in_item random_item();
        pcio_pkg::t_in_item it;
        int                 pick;
        it.value          = 8'($urandom);
        it.last_code      = 1'($urandom_range(0, 1));
        it.cpu_int_enable = 1'($urandom_range(0, 1));
        it.port           = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            it.command = pcio_pkg::CMD_TICK;
        end else if (pick < 50) begin
            it.command = pcio_pkg::CMD_PUSH;
        end else if (pick < 72) begin
            it.command = pcio_pkg::CMD_READ;
            pick = $urandom_range(0, 9);
            if (pick < 5)
                it.port = pcio_pkg::PORT_KBD_DATA;
            else if (pick < 9)
                it.port = KNOWN_PORTS[$urandom_range(0, 9)];
        end else begin
            it.command = pcio_pkg::CMD_WRITE;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                it.port = pcio_pkg::PORT_PIC_CMD;
                if ($urandom_range(0, 9) != 0)
                    it.value = pcio_pkg::PIC_EOI;
            end else if (pick < 8) begin
                it.port = pcio_pkg::PORT_PIC_MASK;
                if ($urandom_range(0, 9) < 7)
                    it.value[1:0] = 2'b00;
            end else if (pick < 9) begin
                it.port = pcio_pkg::PORT_TIMER_CTL;
            end else if ($urandom_range(0, 1) == 0) begin
                it.port = KNOWN_PORTS[$urandom_range(0, 9)];
            end
        end
        return it;
    endfunction

    task automatic send(pcio_pkg::t_in_item it);
        int gap;
        gap = draw_gap(in_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_item     <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap(out_calm);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        pcio_pkg::t_in_item directed[$];

        directed.push_back(make_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_PIC_MASK,
                                     8'h00, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_KBD_CTL,
                                     8'h00, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_SERIAL_LSR,
                                     8'h00, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_VIDEO_STATUS,
                                     8'h00, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_VIDEO_STATUS,
                                     8'h00, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_TIMER0,
                                     8'h00, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_TIMER1,
                                     8'h00, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_TIMER2,
                                     8'h00, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_TIMER_CTL,
                                     8'h00, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_TIMER0,
                                     8'h00, 1'b0, 1'b1));
        // empty queue and unknown ports
        directed.push_back(make_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_KBD_DATA,
                                     8'h00, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_READ, 16'hFFFF, 8'h00, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_WRITE, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
        // fill the queue, last push overflows
        directed.push_back(make_item(pcio_pkg::CMD_PUSH, 16'h0000, 8'h00, 1'b0, 1'b0));
        directed.push_back(make_item(pcio_pkg::CMD_PUSH, 16'h0000, 8'hFF, 1'b0, 1'b0));
        directed.push_back(make_item(pcio_pkg::CMD_PUSH, 16'h0000, 8'h1E, 1'b0, 1'b0));
        directed.push_back(make_item(pcio_pkg::CMD_PUSH, 16'h0000, 8'h9E, 1'b0, 1'b0));
        directed.push_back(make_item(pcio_pkg::CMD_PUSH, 16'h0000, 8'h2A, 1'b1, 1'b0));
        directed.push_back(make_item(pcio_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b0, 1'b0));
        directed.push_back(make_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_KBD_DATA,
                                     8'h00, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_PIC_CMD,
                                     8'h55, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_PIC_CMD,
                                     pcio_pkg::PIC_EOI, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_PIC_MASK,
                                     8'hFF, 1'b0, 1'b1));
        repeat (3) directed.push_back(make_item(pcio_pkg::CMD_TICK, 16'h0000,
                                                8'h00, 1'b0, 1'b1));
        directed.push_back(make_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_PIC_MASK,
                                     8'h00, 1'b0, 1'b1));
        // timer wins, then keyboard, then drain to an empty queue
        repeat (5) directed.push_back(make_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_PIC_CMD,
                                                pcio_pkg::PIC_EOI, 1'b0, 1'b0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send(directed[k]);
        repeat (RANDOM_ITEMS)
            send(random_item());
        i_in_valid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);

        $display("checked %0d transactions: %0d interrupts taken, %0d scancodes dropped",
                 checked, irq_count, ovf_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
